### hdl/xdpte_pkg.sv
// ----------------------------------------------------------------------------
// xdpte_pkg - shared types and constants of the xor delta token encoder
// queue entry layout, token tags and the token builder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xdpte_pkg;

   localparam int unsigned RUN_TABLE_BYTES_DEF = 255;
   localparam int unsigned QUEUE_DEPTH_DEF     = 4;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TOKEN_W = 18;
   localparam int unsigned TBITS_W = 5;
   localparam int unsigned RUNS_W  = 7;
   localparam int unsigned COUNT_W = 9;
   localparam int unsigned ACC_W   = 32;

   // token tags, two bits at the head of each token; short zero run tokens are all zeros and untagged
   localparam logic [1:0] TAG_SINGLE = 2'b01;
   localparam logic [1:0] TAG_SHORT  = 2'b10;
   localparam logic [1:0] TAG_LONG   = 2'b11;

   localparam logic [7:0] ZERO_RUN_MAX   = 8'd7;
   localparam logic [7:0] SHORT_LEN_MAX  = 8'd15;
   localparam logic [7:0] END_MARK       = 8'hC0;

   typedef struct packed {
      logic [TOKEN_W-1:0] bits;   // left aligned
      logic [TBITS_W-1:0] size;
   } token_type;

   typedef struct packed {
      logic               tok_vld;
      logic [TOKEN_W-1:0] tok;
      logic [TBITS_W-1:0] tbits;
      logic               fin;
      logic               err;
      logic [RUNS_W-1:0]  runs;
   } entry_type;

   // token for a run, lenf is the run length minus one
   function automatic token_type make_token(input logic [7:0] lenf, input logic [7:0] value);
      token_type t;
      t.bits = '0;
      t.size = '0;
      priority if (value == 8'd0 && lenf < ZERO_RUN_MAX) begin
         t.bits = '0;
         t.size = TBITS_W'({lenf[2:0], 1'b0} + 4'd2);
      end else if (lenf == 8'd0) begin
         t.bits = {TAG_SINGLE, value, 8'd0};
         t.size = 5'd10;
      end else if (lenf <= SHORT_LEN_MAX) begin
         t.bits = {TAG_SHORT, lenf[3:0], value, 4'd0};
         t.size = 5'd14;
      end else begin
         t.bits = {TAG_LONG, lenf, value};
         t.size = 5'd18;
      end
      return t;
   endfunction

endpackage

### hdl/xor_delta_packed_token_encoder_core.sv
// ----------------------------------------------------------------------------
// xor_delta_packed_token_encoder_core - xor delta run length token encoder
// codes runs of equal xor deltas as packed variable length tokens
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------------
//  req      | in        | req_valid / req_stall  | old_byte, new_byte, last_item
//  rsp      | out       | rsp_valid / rsp_stall  | packed_byte, is_final, counts,
//           |           |                        | overflow
//  csr      | in        | csr_write_enable       | csr_write_data (run table limit)
//
//  a word is taken per cycle unless the queue is full; a last word that closes
//  the open run and starts a new one is held until both runs are queued, one entry each
//  the packer sends one word per cycle unless rsp_stall holds it, so with single-byte
//  tokens (10 bits) per input word the pace is set by the rsp port
//  reset is synchronous and active high; the limit returns to RUN_TABLE_BYTES
//  rsp_stall backs up the packer only; the queue keeps req open until it fills
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xor_delta_packed_token_encoder_core #(
   parameter int unsigned RUN_TABLE_BYTES = xdpte_pkg::RUN_TABLE_BYTES_DEF,
   parameter int unsigned QUEUE_DEPTH     = xdpte_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // run table limit register
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   // byte pairs in
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_old_byte,
   input  logic [7:0] req_new_byte,
   input  logic       req_last_item,
   // packed words out
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_packed_byte,
   output logic       rsp_is_final,
   output logic [8:0] rsp_byte_count,
   output logic [6:0] rsp_run_count,
   output logic       rsp_overflow
);
   import xdpte_pkg::*;

   // front to queue
   logic      q_push;
   logic      q_ready;
   entry_type q_entry;
   // queue to packer
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   // front: xor delta, run tracking, limit check, token build
   xdpte_front #(
      .RUN_TABLE_BYTES (RUN_TABLE_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_old_byte     (req_old_byte),
      .req_new_byte     (req_new_byte),
      .req_last_item    (req_last_item),
      .q_push           (q_push),
      .q_entry          (q_entry),
      .q_ready          (q_ready)
   );

   // decouples classification from bit packing
   xdpte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_ready (q_ready),
      .push_entry (q_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // back: bit accumulator, end mark, result register
   xdpte_packer u_packer (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_entry       (pop_entry),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_is_final    (rsp_is_final),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_run_count   (rsp_run_count),
      .rsp_overflow    (rsp_overflow)
   );

`ifndef NO_ASSERTIONS
   // counts and overflow only ride on the final word
   a_nonfinal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_final |->
         rsp_byte_count == 9'd0 && rsp_run_count == 7'd0 && !rsp_overflow)
      else $error("counts or overflow on a non-final word");

   // a final word with nothing counted is the empty marker
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_final && rsp_byte_count == 9'd0 |-> rsp_packed_byte == 8'd0)
      else $error("final marker carries data");

   // no word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

### hdl/xdpte_front.sv
// ----------------------------------------------------------------------------
// xdpte_front - run tracking and token classification
// forms the xor delta, follows the open run, checks the run table limit
// and queues one token entry per coded run, or a tokenless one for a suppressed last run
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xdpte_front #(
   parameter int unsigned RUN_TABLE_BYTES = xdpte_pkg::RUN_TABLE_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [7:0]            csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_old_byte,
   input  logic [7:0]            req_new_byte,
   input  logic                  req_last_item,
   output logic                  q_push,
   output xdpte_pkg::entry_type  q_entry,
   input  logic                  q_ready
);
   import xdpte_pkg::*;

   logic [7:0]        limit_ff, limit_in;
   logic [7:0]        value_ff, value_in;
   logic [7:0]        len_ff, len_in;
   logic [RUNS_W-1:0] runs_ff, runs_in;
   logic              err_ff, err_in;
   logic              phase_ff, phase_in;

   logic [7:0]        diff;
   logic              same;
   logic [8:0]        cnt_new;
   logic              close, a_need, b_need, code, is_b;
   logic              ok_cur, ok_next, two, b_fail, fin;
   logic              push, fire, accept;
   token_type         tok_a, tok_b, tok_cur;
   logic [RUNS_W-1:0] runs_out;
   logic              err_out;

   // room in the run table for one more entry of two bytes, with one byte to spare
   function automatic logic fits(input logic [7:0] runs, input logic [7:0] limit);
      return (10'({runs, 1'b0}) + 10'd3) <= {2'b00, limit};
   endfunction

   assign diff    = req_old_byte ^ req_new_byte;
   assign same    = diff == value_ff;
   assign cnt_new = {1'b0, len_ff} + {8'd0, same};
   assign close   = !same || req_last_item || cnt_new[8];
   assign a_need  = close && cnt_new != 9'd0;
   assign b_need  = req_last_item && !same;
   assign code    = a_need || b_need;

   assign tok_a   = make_token(8'(cnt_new - 9'd1), value_ff);
   assign tok_b   = make_token(8'd0, diff);
   assign is_b    = phase_ff || !a_need;
   assign tok_cur = is_b ? tok_b : tok_a;

   assign ok_cur  = !err_ff && fits({1'b0, runs_ff}, limit_ff);
   assign ok_next = fits(8'({1'b0, runs_ff} + 8'd1), limit_ff);
   assign two     = !phase_ff && a_need && b_need && ok_cur && ok_next;
   assign b_fail  = !is_b && b_need && ok_cur && !ok_next;
   assign fin     = req_last_item && (phase_ff || !two);

   assign runs_out = runs_ff + {{(RUNS_W-1){1'b0}}, code && ok_cur};
   assign err_out  = err_ff || (code && !ok_cur) || b_fail;

   // suppressed runs are queued only when they carry the end of the stream
   assign push   = req_valid && code && (ok_cur || req_last_item);
   assign fire   = req_valid && (!push || q_ready);
   assign accept = fire && !two;

   assign req_stall = req_valid && !accept;
   assign q_push    = push;

   always_comb begin
      q_entry         = '0;
      q_entry.tok_vld = ok_cur;
      q_entry.tok     = tok_cur.bits;
      q_entry.tbits   = tok_cur.size;
      q_entry.fin     = fin;
      q_entry.err     = err_out;
      q_entry.runs    = runs_out;
   end

   always_comb begin
      limit_in = limit_ff;
      value_in = value_ff;
      len_in   = len_ff;
      runs_in  = runs_ff;
      err_in   = err_ff;
      phase_in = phase_ff;
      if (csr_write_enable) begin
         limit_in = csr_write_data;
      end
      if (fire) begin
         runs_in  = runs_out;
         err_in   = err_out;
         phase_in = two;
      end
      if (accept) begin
         if (close) begin
            value_in = diff;
            len_in   = same ? 8'd0 : 8'd1;
         end else begin
            len_in = cnt_new[7:0];
         end
         if (req_last_item) begin
            value_in = '0;
            len_in   = '0;
            runs_in  = '0;
            err_in   = 1'b0;
            phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 8'(RUN_TABLE_BYTES);
         value_ff <= '0;
         len_ff   <= '0;
         runs_ff  <= '0;
         err_ff   <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         value_ff <= value_in;
         len_ff   <= len_in;
         runs_ff  <= runs_in;
         err_ff   <= err_in;
         phase_ff <= phase_in;
      end
   end

endmodule

### hdl/xdpte_queue.sv
// ----------------------------------------------------------------------------
// xdpte_queue - token entry queue
// small register queue between the classifier and the bit packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xdpte_queue #(
   parameter int unsigned DEPTH = xdpte_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  xdpte_pkg::entry_type  push_entry,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output xdpte_pkg::entry_type  pop_entry
);
   import xdpte_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] step(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = fill_ff != CNT_W'(DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_entry  = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? step(rd_ptr_ff) : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:        fill_in = fill_ff + 1'b1;
         2'b01:        fill_in = fill_ff - 1'b1;
         2'b00, 2'b11: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### hdl/xdpte_packer.sv
// ----------------------------------------------------------------------------
// xdpte_packer - msb first bit packer and result register
// merges tokens in a bit accumulator, sends one word per cycle unless stalled,
// end mark after a partial last byte without overflow; counts on final word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xdpte_packer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  xdpte_pkg::entry_type  pop_entry,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_packed_byte,
   output logic                  rsp_is_final,
   output logic [8:0]            rsp_byte_count,
   output logic [6:0]            rsp_run_count,
   output logic                  rsp_overflow
);
   import xdpte_pkg::*;

   logic [ACC_W-1:0]   acc_ff, acc_in, acc_p;
   logic [TBITS_W-1:0] cnt_ff, cnt_in, cnt_p, cnt_rest;
   logic               fin_ff, fin_in, fin_p;
   logic               err_ff, err_in;
   logic [RUNS_W-1:0]  runs_ff, runs_in;
   logic [COUNT_W-1:0] bytes_ff, bytes_in, bytes_p;

   logic               out_vld_ff, out_vld_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_final_ff, out_final_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;
   logic [RUNS_W-1:0]  out_runs_ff, out_runs_in;
   logic               out_ovf_ff, out_ovf_in;

   logic               out_free, has_byte, emit_tok, emit_end, emit;
   logic               last_tok, final_now, end_real, load;
   logic [BYTE_W-1:0]  top_byte;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign has_byte  = cnt_ff >= TBITS_W'(BYTE_W);
   assign cnt_rest  = cnt_ff - TBITS_W'(BYTE_W);
   assign emit_tok  = has_byte && out_free;
   assign emit_end  = !has_byte && fin_ff && out_free;
   assign emit      = emit_tok || emit_end;
   // last token word is final when no end word follows it
   assign last_tok  = emit_tok && fin_ff && cnt_rest < TBITS_W'(BYTE_W)
                      && (err_ff || cnt_rest == '0);
   assign final_now = last_tok || emit_end;
   assign end_real  = !err_ff && cnt_ff != '0;
   assign top_byte  = acc_ff[ACC_W-1 -: BYTE_W];

   always_comb begin
      acc_p   = acc_ff;
      cnt_p   = cnt_ff;
      fin_p   = fin_ff;
      bytes_p = bytes_ff;
      if (final_now) begin
         acc_p   = '0;
         cnt_p   = '0;
         fin_p   = 1'b0;
         bytes_p = '0;
      end else if (emit_tok) begin
         acc_p   = acc_ff << BYTE_W;
         cnt_p   = cnt_rest;
         bytes_p = bytes_ff + 1'b1;
      end
   end

   assign pop_ready = cnt_p < TBITS_W'(BYTE_W) && !fin_p;
   assign load      = pop_valid && pop_ready;

   always_comb begin
      acc_in   = acc_p;
      cnt_in   = cnt_p;
      fin_in   = fin_p;
      err_in   = err_ff;
      runs_in  = runs_ff;
      bytes_in = bytes_p;
      if (load) begin
         if (pop_entry.tok_vld) begin
            acc_in = acc_p | ({pop_entry.tok, {(ACC_W-TOKEN_W){1'b0}}} >> cnt_p);
            cnt_in = cnt_p + pop_entry.tbits;
         end
         fin_in  = pop_entry.fin;
         err_in  = pop_entry.err;
         runs_in = pop_entry.runs;
      end
   end

   always_comb begin
      out_vld_in   = out_vld_ff;
      out_byte_in  = out_byte_ff;
      out_final_in = out_final_ff;
      out_count_in = out_count_ff;
      out_runs_in  = out_runs_ff;
      out_ovf_in   = out_ovf_ff;
      if (emit) begin
         out_vld_in   = 1'b1;
         out_final_in = final_now;
         if (emit_tok) begin
            out_byte_in = top_byte;
         end else if (end_real) begin
            out_byte_in = top_byte | (END_MARK >> cnt_ff[2:0]);
         end else begin
            out_byte_in = '0;   // marker word, not counted
         end
         if (final_now) begin
            out_count_in = (emit_end && !end_real) ? bytes_ff : bytes_ff + 1'b1;
            out_runs_in  = runs_ff;
            out_ovf_in   = err_ff;
         end else begin
            out_count_in = '0;
            out_runs_in  = '0;
            out_ovf_in   = 1'b0;
         end
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         cnt_ff     <= '0;
         fin_ff     <= 1'b0;
         err_ff     <= 1'b0;
         runs_ff    <= '0;
         bytes_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         cnt_ff     <= cnt_in;
         fin_ff     <= fin_in;
         err_ff     <= err_in;
         runs_ff    <= runs_in;
         bytes_ff   <= bytes_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_final_ff <= out_final_in;
      out_count_ff <= out_count_in;
      out_runs_ff  <= out_runs_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_packed_byte = out_byte_ff;
   assign rsp_is_final    = out_final_ff;
   assign rsp_byte_count  = out_count_ff;
   assign rsp_run_count   = out_runs_ff;
   assign rsp_overflow    = out_ovf_ff;

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the xor delta packed token encoder core
// feeds streams of byte pairs, predicts every packed word in a local shadow
// encoder and checks the result words field by field, with random pacing
// on both channels, run table limit changes and a long result-side hold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import xdpte_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 1_000_000;
   localparam int unsigned RUN_FULL       = 256;
   localparam int unsigned SETTLE_CYCLES  = 24;
   localparam int unsigned RANDOM_ITEMS   = 100;
   localparam int unsigned PRESSURE_ITEMS = 30;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam int unsigned LONG_HOLD      = 400;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       is_final;
      logic [8:0] byte_count;
      logic [6:0] run_count;
      logic       overflow;
   } packed_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'd0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_old_byte = 8'd0;
   logic [7:0] req_new_byte = 8'd0;
   logic       req_last_item = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_packed_byte;
   logic       rsp_is_final;
   logic [8:0] rsp_byte_count;
   logic [6:0] rsp_run_count;
   logic       rsp_overflow;

   // shadow encoder state
   logic [7:0]  run_limit;
   logic [7:0]  open_value;
   int unsigned open_length;
   logic [6:0]  runs_coded;
   logic [7:0]  tail_bits;     // msb aligned partial byte
   int unsigned tail_count;
   logic [8:0]  bytes_packed;
   logic        table_overflow;
   int unsigned step_words;

   packed_word_type expected_words[$];

   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned streams_sent = 0;
   int unsigned words_checked = 0;
   int unsigned overflow_streams = 0;
   int unsigned mismatches = 0;
   int unsigned hold_off_request = 0;
   bit          sender_pacing = 1'b1;
   bit          receiver_pacing = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   xor_delta_packed_token_encoder_core u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_old_byte     (req_old_byte),
      .req_new_byte     (req_new_byte),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_byte  (rsp_packed_byte),
      .rsp_is_final     (rsp_is_final),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_run_count    (rsp_run_count),
      .rsp_overflow     (rsp_overflow)
   );

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap(bit enabled);
      int unsigned roll;
      if (!enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic void clear_stream();
      open_value     = 8'd0;
      open_length    = 0;
      runs_coded     = 7'd0;
      tail_bits      = 8'd0;
      tail_count     = 0;
      bytes_packed   = 9'd0;
      table_overflow = 1'b0;
   endfunction

   function automatic void queue_packed_byte(logic [7:0] value);
      packed_word_type w;
      w = '0;
      w.packed_byte = value;
      w.overflow    = table_overflow;
      expected_words.push_back(w);
      step_words++;
   endfunction

   // codes one run as a token and appends it to the msb first bit stream
   function automatic void pack_run_token(int unsigned run_len, logic [7:0] value);
      logic [7:0]  lenf;
      logic [17:0] tok;
      int unsigned tbits;
      int unsigned nb;
      logic [31:0] acc;
      if (table_overflow) return;
      if (2 * int'(runs_coded) + 3 > int'(run_limit)) begin
         table_overflow = 1'b1;
         return;
      end
      runs_coded = runs_coded + 7'd1;
      lenf = 8'(run_len - 1);
      if (value == 8'd0 && lenf < ZERO_RUN_MAX) begin
         tok   = '0;
         tbits = 2 * (int'(lenf) + 1);
      end else if (lenf == 8'd0) begin
         tok   = {8'd0, TAG_SINGLE, value};
         tbits = 10;
      end else if (lenf <= SHORT_LEN_MAX) begin
         tok   = {4'd0, TAG_SHORT, lenf[3:0], value};
         tbits = 14;
      end else begin
         tok   = {TAG_LONG, lenf, value};
         tbits = 18;
      end
      nb  = tail_count;
      acc = 32'(tail_bits) >> (8 - nb);
      acc = (acc << tbits) | 32'(tok);
      nb += tbits;
      while (nb >= 8) begin
         queue_packed_byte(8'(acc >> (nb - 8)));
         bytes_packed = bytes_packed + 9'd1;
         nb -= 8;
      end
      acc &= (32'd1 << nb) - 32'd1;
      tail_bits  = 8'(acc << (8 - nb));
      tail_count = nb;
   endfunction

   // expected words caused by one byte pair
   function automatic void predict_pair(logic [7:0] old_b, logic [7:0] new_b, bit last);
      logic [7:0]      delta;
      logic [7:0]      val;
      int unsigned     cnt;
      packed_word_type closing;
      delta      = old_b ^ new_b;
      val        = open_value;
      cnt        = open_length;
      step_words = 0;
      if (delta == val) cnt++;
      if (delta != val || last || cnt >= RUN_FULL) begin
         if (cnt != 0) pack_run_token(cnt, val);
         if (last && delta != val) pack_run_token(1, delta);
         cnt = (delta != val) ? 1 : 0;
         val = delta;
      end
      open_length = cnt;
      open_value  = val;
      if (last) begin
         // end mark right after the last token, then zero pad
         if (!table_overflow && tail_count != 0) begin
            queue_packed_byte(tail_bits | (END_MARK >> tail_count));
            bytes_packed = bytes_packed + 9'd1;
         end
         // overflow with nothing left to send still closes the stream
         if (step_words == 0) queue_packed_byte(8'd0);
         closing            = expected_words.pop_back();
         closing.is_final   = 1'b1;
         closing.byte_count = bytes_packed;
         closing.run_count  = runs_coded;
         closing.overflow   = table_overflow;
         expected_words.push_back(closing);
         clear_stream();
      end
   endfunction

   function automatic void report_mismatch(string what, packed_word_type want,
                                           packed_word_type seen);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("tb: mismatch (%s) at cycle %0d: expected %02h/%0b/%0d/%0d/%0b,",
                  what, cycle_count,
                  want.packed_byte, want.is_final, want.byte_count, want.run_count, want.overflow,
                  " got %02h/%0b/%0d/%0d/%0b",
                  seen.packed_byte, seen.is_final, seen.byte_count, seen.run_count, seen.overflow);
   endfunction

   function automatic void check_packed_word();
      packed_word_type seen;
      packed_word_type want;
      string           bad;
      seen = {rsp_packed_byte, rsp_is_final, rsp_byte_count, rsp_run_count, rsp_overflow};
      bad  = "";
      words_checked++;
      if (expected_words.size() == 0) begin
         report_mismatch("no word expected", '0, seen);
         return;
      end
      want = expected_words.pop_front();
      if (seen.packed_byte !== want.packed_byte) bad = {bad, " packed_byte"};
      if (seen.is_final !== want.is_final) bad = {bad, " is_final"};
      if (seen.byte_count !== want.byte_count) bad = {bad, " byte_count"};
      if (seen.run_count !== want.run_count) bad = {bad, " run_count"};
      if (seen.overflow !== want.overflow) bad = {bad, " overflow"};
      if (bad.len() != 0) report_mismatch(bad, want, seen);
      if (want.is_final && want.overflow) overflow_streams++;
   endfunction

   // result words are sampled mid-cycle, where nothing moves
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_packed_word();
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // result side pacing; a requested hold is counted here in cycles
   initial begin : rsp_pacing
      int unsigned span;
      forever begin
         @(posedge clock);
         if (hold_off_request != 0) begin
            span = hold_off_request;
            hold_off_request = 0;
            rsp_stall <= 1'b1;
            repeat (span) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (receiver_pacing && $urandom_range(0, 3) == 0) begin
            span = pick_gap(1'b1);
            if (span != 0) begin
               rsp_stall <= 1'b1;
               repeat (span) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // offers one byte pair and returns at the edge that takes it
   task automatic send_pair(input logic [7:0] old_b, input logic [7:0] new_b, input bit last);
      int unsigned gap;
      gap = pick_gap(sender_pacing);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_old_byte  <= old_b;
      req_new_byte  <= new_b;
      req_last_item <= last;
      predict_pair(old_b, new_b, last);
      items_sent++;
      if (last) streams_sent++;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_delta(input logic [7:0] delta, input bit last);
      logic [7:0] old_b;
      old_b = 8'($urandom);
      send_pair(old_b, old_b ^ delta, last);
   endtask

   task automatic send_run(input logic [7:0] delta, input int unsigned len, input bit last);
      for (int unsigned i = 0; i < len; i++) send_delta(delta, last && i == len - 1);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_run_limit(input logic [7:0] limit);
      drain_block();
      csr_write_enable <= 1'b1;
      csr_write_data   <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      run_limit = limit;
   endtask

   // limit as left by reset, short mixed stream ending on a new value
   task automatic test_default_limit();
      send_delta(8'h00, 1'b0);
      send_delta(8'hFF, 1'b0);
      send_delta(8'h01, 1'b1);
   endtask

   task automatic test_field_extremes();
      set_run_limit(8'd255);
      send_pair(8'h00, 8'h00, 1'b0);
      send_pair(8'hFF, 8'hFF, 1'b0);
      send_pair(8'h00, 8'hFF, 1'b0);
      send_pair(8'hFF, 8'h00, 1'b0);
      send_pair(8'hAA, 8'h55, 1'b0);
      send_pair(8'h12, 8'h13, 1'b0);
      send_pair(8'h80, 8'h00, 1'b1);
      // one pair streams, zero and nonzero delta
      send_pair(8'hFF, 8'hFF, 1'b1);
      send_pair(8'h7F, 8'h80, 1'b1);
   endtask

   // zero run 7/8 and the short/long token boundary
   task automatic test_run_lengths();
      set_run_limit(8'd255);
      send_run(8'h00, 7, 1'b0);
      send_delta(8'h03, 1'b0);
      send_run(8'h00, 8, 1'b0);
      send_run(8'h11, 16, 1'b0);
      send_run(8'h3C, 17, 1'b0);
      send_delta(8'h42, 1'b1);
   endtask

   task automatic test_overflow();
      set_run_limit(8'd3);
      send_delta(8'h01, 1'b0);
      send_delta(8'h02, 1'b0);
      send_delta(8'h03, 1'b0);
      send_delta(8'h03, 1'b1);
   endtask

   // first run already overflows, stream closes with the marker word
   task automatic test_limit_below_three();
      set_run_limit(8'd0);
      send_delta(8'h05, 1'b0);
      send_delta(8'h05, 1'b1);
   endtask

   // results held back for a long stretch while single tokens keep coming
   task automatic test_backpressure();
      set_run_limit(8'd255);
      sender_pacing    = 1'b0;
      hold_off_request = LONG_HOLD;
      for (int unsigned i = 0; i < PRESSURE_ITEMS; i++)
         send_delta(8'(i * 37 + 1), i == PRESSURE_ITEMS - 1);
      sender_pacing = 1'b1;
   endtask

   task automatic test_random_streams();
      int unsigned sent;
      int unsigned nruns;
      int unsigned len;
      int unsigned roll;
      logic [7:0]  value;
      logic [7:0]  limit;
      bit          last;
      sent  = 0;
      value = 8'd0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            roll = $urandom_range(0, 3);
            case (roll)
               0: limit = 8'd3;
               1: limit = 8'd255;
               2: limit = 8'($urandom_range(3, 12));
               default: limit = 8'($urandom_range(3, 255));
            endcase
            set_run_limit(limit);
         end
         sender_pacing   = ($urandom_range(0, 4) != 0);
         receiver_pacing = ($urandom_range(0, 4) != 0);
         nruns = $urandom_range(1, 8);
         for (int unsigned r = 0; r < nruns; r++) begin
            roll = $urandom_range(0, 3);
            case (roll)
               0: value = 8'h00;
               1: value = 8'($urandom);
               2: ;  // same delta again, runs merge
               default: value = ($urandom_range(0, 1) == 0) ? 8'h80 : 8'hFF;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 70) len = $urandom_range(1, 4);
            else if (roll < 90) len = $urandom_range(5, 17);
            else len = $urandom_range(18, 40);
            for (int unsigned i = 0; i < len; i++) begin
               last = (r == nruns - 1) && (i == len - 1);
               if ($urandom_range(0, 5) == 0) send_pair(8'($urandom), 8'($urandom), last);
               else send_delta(value, last);
               sent++;
            end
         end
      end
      sender_pacing   = 1'b1;
      receiver_pacing = 1'b1;
   endtask

   initial begin
      run_limit = 8'(RUN_TABLE_BYTES_DEF);
      clear_stream();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_default_limit();
      test_field_extremes();
      test_overflow();
      test_limit_below_three();
      test_run_lengths();
      test_backpressure();
      test_random_streams();

      drain_block();
      if (expected_words.size() != 0) begin
         mismatches += expected_words.size();
         $display("tb: %0d expected words never arrived", expected_words.size());
      end
      $display("tb: %0d byte pairs in %0d streams, %0d packed words checked",
               items_sent, streams_sent, words_checked);
      $display("tb: %0d streams hit the table limit, limits 0 to 255, %0d mismatches",
               overflow_streams, mismatches);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

### files.f
hdl/xdpte_pkg.sv
hdl/xdpte_front.sv
hdl/xdpte_queue.sv
hdl/xdpte_packer.sv
hdl/xor_delta_packed_token_encoder_core.sv
bench/tb.sv
